/* rtl/mau_pkg.sv */
// ----------------------------------------------------------------------------
// mau_pkg
// Shared widths, opcodes and sequencer states of the modular arithmetic unit.
// ----------------------------------------------------------------------------
package mau_pkg;

  // operand and modulus width
  localparam int WIDTH = 16;
  // bit counter for one serial pass over WIDTH bits
  localparam int CNT_W = $clog2(WIDTH);
  localparam int OPC_W = 2;

  // stream payload widths, rounded up to whole bytes
  localparam int IN_DATA_W  = ((2 * WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((WIDTH + 7) / 8) * 8;

  // operation codes
  localparam logic [OPC_W-1:0] OP_ADD = 2'd0;
  localparam logic [OPC_W-1:0] OP_MUL = 2'd1;
  localparam logic [OPC_W-1:0] OP_NEG = 2'd2;
  localparam logic [OPC_W-1:0] OP_INV = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_EXEC,
    S_MUL_START,
    S_MUL_WAIT,
    S_EXP_START,
    S_EXP_WAIT,
    S_DONE
  } state_t;

endpackage

/* rtl/modular_arithmetic_unit_top.sv */
// ----------------------------------------------------------------------------
// modular_arithmetic_unit_top
// An inverse of a zero operand skips the exponentiation.
// One item at a time; the rate is set by the bit-serial reduction and modular
// multipliers, one bit per cycle, 16 multiply passes for an inverse.
// Synchronous active-low reset; the modulus resets to 2.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration: modulus
  input  logic                           cfg_wr_en,
  input  logic [mau_pkg::WIDTH-1:0]      cfg_wr_data,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mau_pkg::IN_DATA_W-1:0]  in_tdata,   // operand_a, operand_b
  input  logic [mau_pkg::OPC_W-1:0]      in_tuser,   // opcode
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mau_pkg::OUT_DATA_W-1:0] out_tdata,  // value
  output logic                           out_tuser   // ok
);
  import mau_pkg::*;

  logic [WIDTH-1:0] modulus_r;
  logic [WIDTH-1:0] m_eff;
  logic             seq_ready;
  logic             res_valid;
  logic             res_take;
  logic [WIDTH-1:0] res_value;
  logic             res_ok;
  logic             out_valid_r;
  logic [WIDTH-1:0] out_value_r;
  logic             out_ok_r;

  // modulus register, values below two act as two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= WIDTH'(2);
    end else if (cfg_wr_en) begin
      modulus_r <= cfg_wr_data;
    end
  end

  assign m_eff = (modulus_r < WIDTH'(2)) ? WIDTH'(2) : modulus_r;

  assign in_tready = seq_ready;

  mau_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_tvalid && seq_ready),
    .opcode    (in_tuser),
    .operand_a (in_tdata[WIDTH-1:0]),
    .operand_b (in_tdata[2*WIDTH-1:WIDTH]),
    .m         (m_eff),
    .ready     (seq_ready),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_value (res_value),
    .res_ok    (res_ok)
  );

  // output register, loads when empty or being drained
  assign res_take = res_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_value_r <= res_value;
      out_ok_r    <= res_ok;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_value_r);
  assign out_tuser  = out_ok_r;

endmodule

/* rtl/mau_modmul.sv */
// ----------------------------------------------------------------------------
// mau_modmul
// Bit-serial modular multiplier: scans y from the top bit down, doubling the
// partial product and adding x on set bits, kept reduced below m every cycle.
// ----------------------------------------------------------------------------
module mau_modmul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mau_pkg::WIDTH-1:0] x,
  input  logic [mau_pkg::WIDTH-1:0] y,
  input  logic [mau_pkg::WIDTH-1:0] m,
  output logic                      done,
  output logic [mau_pkg::WIDTH-1:0] prod
);
  import mau_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [WIDTH-1:0] x_r;
  logic [WIDTH-1:0] y_r;
  logic [WIDTH-1:0] acc_r;
  logic [WIDTH-1:0] acc_nxt;

  logic [WIDTH+1:0] sum;
  logic [WIDTH+1:0] m1;
  logic [WIDTH+1:0] m2;

  // one step: 2*acc + bit*x is below 3m, so subtract m or 2m in parallel
  always_comb begin
    m1  = {2'b00, m};
    m2  = {1'b0, m, 1'b0};
    sum = {1'b0, acc_r, 1'b0} + (y_r[WIDTH-1] ? {2'b00, x_r} : '0);
    if (sum >= m2) begin
      acc_nxt = WIDTH'(sum - m2);
    end else if (sum >= m1) begin
      acc_nxt = WIDTH'(sum - m1);
    end else begin
      acc_nxt = sum[WIDTH-1:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(WIDTH - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operand shift register and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x;
      y_r   <= y;
      acc_r <= '0;
    end else if (busy_r) begin
      y_r   <= {y_r[WIDTH-2:0], 1'b0};
      acc_r <= acc_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

/* rtl/mau_seq.sv */
// ----------------------------------------------------------------------------
// mau_seq
// Operation sequencer: serial reduction of the operands, then add, negate,
// one serial multiply, or a square-and-multiply exponentiation to m-2.
// ----------------------------------------------------------------------------
module mau_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mau_pkg::OPC_W-1:0] opcode,
  input  logic [mau_pkg::WIDTH-1:0] operand_a,
  input  logic [mau_pkg::WIDTH-1:0] operand_b,
  input  logic [mau_pkg::WIDTH-1:0] m,
  output logic                      ready,
  output logic                      res_valid,
  input  logic                      res_take,
  output logic [mau_pkg::WIDTH-1:0] res_value,
  output logic                      res_ok
);
  import mau_pkg::*;

  state_t           state_r;
  state_t           state_nxt;
  logic [OPC_W-1:0] op_r;
  logic [CNT_W-1:0] cnt_r;
  logic [WIDTH-1:0] ra_r;
  logic [WIDTH-1:0] rb_r;
  logic [WIDTH-1:0] a_r;
  logic [WIDTH-1:0] b_r;
  logic [WIDTH-1:0] exp_r;
  logic [WIDTH-1:0] res_r;
  logic             ok_r;
  logic             zero_r;

  logic [WIDTH-1:0] a_nxt;
  logic [WIDTH-1:0] b_nxt;
  logic [WIDTH:0]   ta;
  logic [WIDTH:0]   tb;
  logic [WIDTH:0]   add_s;
  logic [WIDTH-1:0] add_res;
  logic [WIDTH-1:0] neg_res;
  logic             last_bit;

  logic             mm_start;
  logic [WIDTH-1:0] mx;
  logic             done_a;
  logic             done_b;
  logic [WIDTH-1:0] prod_a;
  logic [WIDTH-1:0] prod_b;

  assign last_bit = (cnt_r == CNT_W'(WIDTH - 1));

  // serial reduction: shift in the next raw bit, subtract m once if needed
  always_comb begin
    ta = {a_r, ra_r[WIDTH-1]};
    tb = {b_r, rb_r[WIDTH-1]};
    a_nxt = (ta >= {1'b0, m}) ? WIDTH'(ta - {1'b0, m}) : ta[WIDTH-1:0];
    b_nxt = (tb >= {1'b0, m}) ? WIDTH'(tb - {1'b0, m}) : tb[WIDTH-1:0];
  end

  // combinational add and additive inverse on reduced operands
  always_comb begin
    add_s   = {1'b0, a_r} + {1'b0, b_r};
    add_res = (add_s >= {1'b0, m}) ? WIDTH'(add_s - {1'b0, m}) : add_s[WIDTH-1:0];
    neg_res = (a_r == '0) ? '0 : m - a_r;
  end

  // multiplier A: a*b for multiply, acc*base for the power; B squares the base
  assign mx = (op_r == OP_INV) ? res_r : a_r;

  mau_modmul u_mul_a (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mm_start),
    .x     (mx),
    .y     ((op_r == OP_INV) ? a_r : b_r),
    .m     (m),
    .done  (done_a),
    .prod  (prod_a)
  );

  mau_modmul u_mul_b (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mm_start),
    .x     (a_r),
    .y     (a_r),
    .m     (m),
    .done  (done_b),
    .prod  (prod_b)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_RED;
      end
      S_RED: begin
        if (last_bit) begin
          case (op_r)
            OP_ADD:  state_nxt = S_EXEC;
            OP_NEG:  state_nxt = S_EXEC;
            OP_MUL:  state_nxt = S_MUL_START;
            default: state_nxt = zero_r ? S_DONE : S_EXP_START;
          endcase
        end
      end
      S_EXEC:      state_nxt = S_DONE;
      S_MUL_START: state_nxt = S_MUL_WAIT;
      S_MUL_WAIT: begin
        if (done_a) state_nxt = S_DONE;
      end
      S_EXP_START: state_nxt = S_EXP_WAIT;
      S_EXP_WAIT: begin
        if (done_a && done_b) state_nxt = last_bit ? S_DONE : S_EXP_START;
      end
      S_DONE: begin
        if (res_take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ready     = 1'b0;
    res_valid = 1'b0;
    mm_start  = 1'b0;
    case (state_r)
      S_IDLE:      ready     = 1'b1;
      S_MUL_START: mm_start  = 1'b1;
      S_EXP_START: mm_start  = 1'b1;
      S_DONE:      res_valid = 1'b1;
      default: begin
        ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_r   <= opcode;
          ra_r   <= operand_a;
          rb_r   <= operand_b;
          a_r    <= '0;
          b_r    <= '0;
          cnt_r  <= '0;
          exp_r  <= m - WIDTH'(2);
          zero_r <= (operand_a == '0);
          ok_r   <= !((opcode == OP_INV) && (operand_a == '0));
          res_r  <= ((opcode == OP_INV) && (operand_a == '0)) ? '0 : WIDTH'(1);
        end
      end
      S_RED: begin
        a_r   <= a_nxt;
        b_r   <= b_nxt;
        ra_r  <= {ra_r[WIDTH-2:0], 1'b0};
        rb_r  <= {rb_r[WIDTH-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
      end
      S_EXEC: begin
        res_r <= (op_r == OP_ADD) ? add_res : neg_res;
      end
      S_MUL_WAIT: begin
        if (done_a) res_r <= prod_a;
      end
      S_EXP_WAIT: begin
        if (done_a && done_b) begin
          if (exp_r[0]) res_r <= prod_a;
          a_r   <= prod_b;
          exp_r <= {1'b0, exp_r[WIDTH-1:1]};
          cnt_r <= cnt_r + 1'b1;
        end
      end
      default: begin
        res_r <= res_r;
      end
    endcase
  end

  assign res_value = res_r;
  assign res_ok    = ok_r;

endmodule

/* tb/modular_arithmetic_unit_top_tb.sv */
// ----------------------------------------------------------------------------
// modular_arithmetic_unit_top_tb
// Self-checking bench for the modular arithmetic unit. A directed table covers
// the field extremes, all four operations, zero and multiple-of-modulus
// operands and the degenerate modulus values; then random phases run under
// several modulus settings. Each result transfer is checked against a typed-in
// or in-bench predicted result, with random input bursts and output stalls.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mau_pkg::*;

  localparam int    HALF_PERIOD  = 6;
  localparam int    RAND_PHASES  = 10;
  localparam int    PHASE_ITEMS  = 133;
  localparam int    TAIL_CYCLES  = 320;
  localparam int    MAX_REPORTS  = 10;
  localparam int    DIR_ROWS     = 25;

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [OPC_W-1:0] opc_t;

  // one expected result transfer
  typedef struct packed {
    word_t value;
    logic  ok;
  } mau_result_t;

  // directed row: optional modulus write, item, optional typed-in result
  typedef struct packed {
    bit    set_mod;
    word_t modulus;
    opc_t  op;
    word_t a;
    word_t b;
    bit    typed;
    word_t value;
    bit    ok;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // reset modulus 2
    '{1'b0, 16'd0,     OP_ADD, 16'h0000, 16'h0000, 1'b1, 16'd0, 1'b1},
    '{1'b0, 16'd0,     OP_ADD, 16'hffff, 16'hffff, 1'b1, 16'd0, 1'b1},
    '{1'b0, 16'd0,     OP_MUL, 16'hffff, 16'hffff, 1'b1, 16'd1, 1'b1},
    '{1'b0, 16'd0,     OP_NEG, 16'h0001, 16'hffff, 1'b1, 16'd1, 1'b1},
    '{1'b0, 16'd0,     OP_INV, 16'h0000, 16'hffff, 1'b1, 16'd0, 1'b0},
    '{1'b0, 16'd0,     OP_INV, 16'h0002, 16'h0000, 1'b1, 16'd1, 1'b1},
    '{1'b0, 16'd0,     OP_INV, 16'h0001, 16'h0000, 1'b1, 16'd1, 1'b1},
    // small prime
    '{1'b1, 16'd7,     OP_ADD, 16'd6,    16'd6,    1'b1, 16'd5, 1'b1},
    '{1'b0, 16'd0,     OP_MUL, 16'd3,    16'd5,    1'b1, 16'd1, 1'b1},
    '{1'b0, 16'd0,     OP_NEG, 16'd0,    16'd0,    1'b1, 16'd0, 1'b1},
    '{1'b0, 16'd0,     OP_NEG, 16'd9,    16'd0,    1'b1, 16'd5, 1'b1},
    '{1'b0, 16'd0,     OP_INV, 16'd3,    16'h1234, 1'b1, 16'd5, 1'b1},
    '{1'b0, 16'd0,     OP_INV, 16'd7,    16'd0,    1'b1, 16'd0, 1'b1},
    '{1'b0, 16'd0,     OP_INV, 16'd0,    16'd0,    1'b1, 16'd0, 1'b0},
    // largest modulus, not prime
    '{1'b1, 16'hffff,  OP_ADD, 16'hffff, 16'hffff, 1'b1, 16'd0, 1'b1},
    '{1'b0, 16'd0,     OP_MUL, 16'hfffe, 16'hfffe, 1'b1, 16'd1, 1'b1},
    '{1'b0, 16'd0,     OP_INV, 16'hffff, 16'd0,    1'b1, 16'd0, 1'b1},
    '{1'b0, 16'd0,     OP_INV, 16'h0002, 16'd0,    1'b0, 16'd0, 1'b0},
    '{1'b0, 16'd0,     OP_MUL, 16'h8000, 16'hfffd, 1'b0, 16'd0, 1'b0},
    // modulus 0 and 1 fall back to 2
    '{1'b1, 16'd0,     OP_NEG, 16'h0001, 16'd0,    1'b1, 16'd1, 1'b1},
    '{1'b0, 16'd0,     OP_INV, 16'h0003, 16'd0,    1'b1, 16'd1, 1'b1},
    '{1'b1, 16'd1,     OP_MUL, 16'h0001, 16'h0001, 1'b1, 16'd1, 1'b1},
    // modulus 3 and a large prime
    '{1'b1, 16'd3,     OP_INV, 16'h0002, 16'd0,    1'b1, 16'd2, 1'b1},
    '{1'b0, 16'd0,     OP_INV, 16'hffff, 16'd0,    1'b1, 16'd0, 1'b1},
    '{1'b1, 16'd65521, OP_INV, 16'h1234, 16'd0,    1'b0, 16'd0, 1'b0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [WIDTH-1:0]      cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;    // operand_a, operand_b
  logic [OPC_W-1:0]      in_tuser;    // opcode
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic [OUT_DATA_W-1:0] out_tdata;   // value
  logic                  out_tuser;   // ok

  // bench copy of the modulus register (raw written value)
  word_t       mod_reg;
  mau_result_t pending_results [$];

  // typed-in expectation for the next input transfer
  bit          typed_en;
  mau_result_t typed_res;

  int n_fail;
  int n_checked;
  int n_ops [4];
  int n_zero_inv;
  int n_mod_writes;
  int burst_left;
  int gap_max;
  int rx_mode;
  int rx_stall_left;
  int rx_run_left;

  modular_arithmetic_unit_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  // clock
  always #HALF_PERIOD clk = ~clk;

  // hard limit on run time
  initial begin
    #30_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // modulus actually in effect
  function automatic longint unsigned eff_modulus();
    return (mod_reg < 2) ? 64'd2 : 64'(mod_reg);
  endfunction

  // expected result of one operation under the current modulus
  function automatic mau_result_t mau_predict(opc_t op, word_t a_raw, word_t b_raw);
    longint unsigned m;
    longint unsigned a;
    longint unsigned b;
    longint unsigned ex;
    longint unsigned acc;
    longint unsigned base;
    mau_result_t     r;
    m = eff_modulus();
    a = 64'(a_raw) % m;
    b = 64'(b_raw) % m;
    r.ok = 1'b1;
    acc = 0;
    case (op)
      OP_ADD: acc = (a + b) % m;
      OP_MUL: acc = (a * b) % m;
      OP_NEG: acc = (m - a) % m;
      default: begin
        if (a_raw == '0) begin
          r.ok = 1'b0;
          acc = 0;
        end else begin
          // square-and-multiply over all WIDTH exponent bits
          ex = m - 2;
          base = a;
          acc = 1 % m;
          for (int i = 0; i < WIDTH; i++) begin
            if (ex[i]) acc = (acc * base) % m;
            base = (base * base) % m;
          end
        end
      end
    endcase
    r.value = word_t'(acc);
    return r;
  endfunction

  task automatic note_fail(string what);
    n_fail++;
    if (n_fail <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // input transfers: record the expected result
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      if (typed_en) pending_results.push_back(typed_res);
      else pending_results.push_back(mau_predict(in_tuser, in_tdata[WIDTH-1:0],
                                                 in_tdata[2*WIDTH-1:WIDTH]));
      n_ops[in_tuser]++;
      if (in_tuser == OP_INV && in_tdata[WIDTH-1:0] == '0) n_zero_inv++;
    end
  end

  // result transfers: compare with the oldest expectation
  always @(posedge clk) begin
    mau_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        note_fail($sformatf("unexpected result value=%0d ok=%0d", out_tdata, out_tuser));
      end else begin
        exp_r = pending_results.pop_front();
        n_checked++;
        if (out_tdata[WIDTH-1:0] !== exp_r.value)
          note_fail($sformatf("value expected %0d actual %0d (modulus %0d)",
                              exp_r.value, out_tdata, eff_modulus()));
        if (out_tuser !== exp_r.ok)
          note_fail($sformatf("ok expected %0d actual %0d (value %0d)",
                              exp_r.ok, out_tuser, exp_r.value));
      end
    end
  end

  // receiver stall pattern: always ready, random, or long stalls
  always @(negedge clk) begin
    if (rx_stall_left != 0) begin
      rx_stall_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 9) < 7);
        default: begin
          if (rx_run_left != 0) begin
            rx_run_left--;
            out_tready <= 1'b1;
          end else begin
            rx_stall_left = $urandom_range(1, 20);
            rx_run_left = $urandom_range(1, 12);
            out_tready <= 1'b0;
          end
        end
      endcase
    end
  end

  // offer one item, with random gaps between bursts; returns at a falling edge
  task automatic send_item(opc_t op, word_t a, word_t b);
    if (burst_left == 0) begin
      if (gap_max != 0) begin
        in_tvalid <= 1'b0;
        in_tdata <= $urandom;
        in_tuser <= opc_t'($urandom_range(0, 3));
        repeat ($urandom_range(1, gap_max)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {b, a};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // hold the input until every expected result has come back
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic set_modulus(word_t m);
    wait_results_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    mod_reg = m;
    n_mod_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // operand mix: edges, modulus neighbors, multiples of m, full random
  function automatic word_t pick_operand();
    longint unsigned m;
    m = eff_modulus();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return '1;
      2: return word_t'(m);
      3: return word_t'(m - 1);
      4: return word_t'(m * $urandom_range(1, 65535 / int'(m)));
      5: return word_t'($urandom_range(0, 3));
      default: return word_t'($urandom);
    endcase
  endfunction

  // stimulus
  initial begin
    word_t phase_mod [RAND_PHASES];
    opc_t  op;
    word_t a;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_ADD;
    typed_en = 1'b0;
    typed_res = '0;
    mod_reg = 16'd2;
    n_fail = 0;
    n_checked = 0;
    n_ops = '{0, 0, 0, 0};
    n_zero_inv = 0;
    n_mod_writes = 0;
    burst_left = 0;
    gap_max = 6;
    rx_mode = 0;
    rx_stall_left = 0;
    rx_run_left = 0;
    phase_mod = '{16'd65521, 16'd2, 16'hffff, 16'd3, 16'd251, 16'd0,
                  word_t'($urandom_range(2, 65535)), 16'd1, 16'd32749, 16'hfffe};

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TAB[i].set_mod) set_modulus(DIR_TAB[i].modulus);
      typed_en = DIR_TAB[i].typed;
      typed_res = '{DIR_TAB[i].value, DIR_TAB[i].ok};
      send_item(DIR_TAB[i].op, DIR_TAB[i].a, DIR_TAB[i].b);
    end
    typed_en = 1'b0;

    // random phases, one modulus setting and one traffic pattern each
    for (int p = 0; p < RAND_PHASES; p++) begin
      set_modulus(phase_mod[p]);
      rx_mode = p % 3;
      gap_max = (p % 4 == 3) ? 0 : 20;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        op = opc_t'($urandom_range(0, 3));
        a = pick_operand();
        send_item(op, a, pick_operand());
        if ($urandom_range(0, 49) == 0) wait_results_drained();
      end
    end

    wait_results_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    if (pending_results.size() != 0)
      note_fail($sformatf("%0d results never arrived", pending_results.size()));
    $display("covered %0d add, %0d mul, %0d neg, %0d inv (%0d of zero) items",
             n_ops[OP_ADD], n_ops[OP_MUL], n_ops[OP_NEG], n_ops[OP_INV], n_zero_inv);
    $display("%0d results checked across %0d modulus writes, %0d failures",
             n_checked, n_mod_writes, n_fail);
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
